// ===== rtl/gpf_pkg.sv =====
package gpf_pkg;

  // Pipeline depths of the iterative units, two result bits per stage
  localparam int SQ_STG  = 16;
  localparam int DIV_STG = 32;

  // Configuration register indexes
  localparam logic [1:0] REG_SOFT  = 2'd0;
  localparam logic [1:0] REG_GRAV  = 2'd1;
  localparam logic [1:0] REG_FLOOR = 2'd2;

  // Reset values of the configuration registers
  localparam logic [47:0] SOFT_RST  = 48'd0;
  localparam logic [31:0] GRAV_RST  = 32'd16777216;
  localparam logic [31:0] FLOOR_RST = 32'd1;

  // Magnitude cap and largest positive output
  localparam logic [47:0] MAG_CAP = 48'h8000_0000_0000;
  localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [31:0]        first_mass;
    logic [31:0]        second_mass;
    logic [30:0]        first_radius;
    logic [30:0]        second_radius;
  } gpf_in_t;

  typedef struct packed {
    logic signed [47:0] first_acc_x;
    logic signed [47:0] first_acc_y;
    logic signed [47:0] first_acc_z;
    logic signed [47:0] first_pot;
    logic signed [47:0] second_acc_x;
    logic signed [47:0] second_acc_y;
    logic signed [47:0] second_acc_z;
    logic signed [47:0] second_pot;
    logic               collided;
  } gpf_out_t;

  // Per-pair data that rides alongside the arithmetic
  typedef struct packed {
    logic              collided;
    logic [1:0]        light;
    logic signed [5:0] e;
    logic [2:0]        dpos;
    logic [2:0]        dneg;
    logic [2:0][31:0]  ad;
  } gpf_side_t;

  typedef struct packed {
    gpf_side_t        side;
    logic [1:0][63:0] n;
  } gpf_nside_t;

  typedef struct packed {
    gpf_side_t        side;
    logic [1:0][63:0] q1;
  } gpf_qside_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] sh;
  } gpf_div_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] m;
  } gpf_sq_t;

  // One restoring division step: shift in the next numerator bit
  function automatic gpf_div_t div_step(gpf_div_t cur, logic [31:0] s);
    logic [32:0] t;
    logic        q;
    gpf_div_t    res;
    t = {cur.rem, cur.sh[63]};
    q = 1'b0;
    if (t >= {1'b0, s}) begin
      t = t - {1'b0, s};
      q = 1'b1;
    end
    res.rem = t[31:0];
    res.sh  = {cur.sh[62:0], q};
    return res;
  endfunction

  // One digit-by-digit square root step over the next two radicand bits
  function automatic gpf_sq_t sqrt_step(gpf_sq_t cur);
    logic [35:0] t;
    logic [35:0] tr;
    logic        b;
    gpf_sq_t     res;
    t  = {cur.rem, cur.m[63:62]};
    tr = {2'b00, cur.root, 2'b01};
    b  = 1'b0;
    if (t >= tr) begin
      t = t - tr;
      b = 1'b1;
    end
    res.rem  = t[33:0];
    res.root = {cur.root[30:0], b};
    res.m    = {cur.m[61:0], 2'b00};
    return res;
  endfunction

  // Count leading zeros of a non-zero word
  function automatic logic [5:0] lzc64(logic [63:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 6'(63 - i);
    end
    return n;
  endfunction

endpackage

// ===== rtl/gpf_sqrt.sv =====
module gpf_sqrt import gpf_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [63:0]       m_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [31:0]       s_o,
  output logic [SIDE_W-1:0] side_o
);

  gpf_sq_t           st_r   [SQ_STG];
  gpf_sq_t           st_nxt [SQ_STG];
  logic [SIDE_W-1:0] side_r [SQ_STG];
  logic [SQ_STG-1:0] vld_r;

  // Two root bits per stage
  always_comb begin
    gpf_sq_t cur;
    for (int g = 0; g < SQ_STG; g++) begin
      if (g == 0) begin
        cur.rem  = '0;
        cur.root = '0;
        cur.m    = m_i;
      end else begin
        cur = st_r[g-1];
      end
      st_nxt[g] = sqrt_step(sqrt_step(cur));
    end
  end

  // Advance the stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < SQ_STG; g++) begin
        st_r[g]   <= st_nxt[g];
        side_r[g] <= (g == 0) ? side_i : side_r[g-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQ_STG-2:0], vld_i};
    end
  end

  assign vld_o  = vld_r[SQ_STG-1];
  assign s_o    = st_r[SQ_STG-1].root;
  assign side_o = side_r[SQ_STG-1];

endmodule

// ===== rtl/gpf_div.sv =====
module gpf_div import gpf_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [1:0][63:0]  x_i,
  input  logic [31:0]       s_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [1:0][63:0]  q_o,
  output logic [31:0]       s_o,
  output logic [SIDE_W-1:0] side_o
);

  // Quotient floor(x * 2^31 / s) for two lanes sharing one divisor
  gpf_div_t           st_r   [DIV_STG][2];
  gpf_div_t           st_nxt [DIV_STG][2];
  logic [31:0]        s_r    [DIV_STG];
  logic [SIDE_W-1:0]  side_r [DIV_STG];
  logic [DIV_STG-1:0] vld_r;

  // Two quotient bits per stage; the top 31 numerator bits start as remainder
  always_comb begin
    gpf_div_t    cur;
    logic [31:0] sd;
    for (int g = 0; g < DIV_STG; g++) begin
      sd = (g == 0) ? s_i : s_r[g-1];
      for (int l = 0; l < 2; l++) begin
        if (g == 0) begin
          cur.rem = {1'b0, x_i[l][63:33]};
          cur.sh  = {x_i[l][32:0], 31'd0};
        end else begin
          cur = st_r[g-1][l];
        end
        st_nxt[g][l] = div_step(div_step(cur, sd), sd);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < DIV_STG; g++) begin
        st_r[g][0] <= st_nxt[g][0];
        st_r[g][1] <= st_nxt[g][1];
        s_r[g]     <= (g == 0) ? s_i : s_r[g-1];
        side_r[g]  <= (g == 0) ? side_i : side_r[g-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STG-2:0], vld_i};
    end
  end

  assign vld_o   = vld_r[DIV_STG-1];
  assign q_o[0]  = st_r[DIV_STG-1][0].sh;
  assign q_o[1]  = st_r[DIV_STG-1][1].sh;
  assign s_o     = s_r[DIV_STG-1];
  assign side_o  = side_r[DIV_STG-1];

endmodule

// ===== rtl/gravity_pair_force_unit.sv =====
// Softened gravity for one particle pair per request.
// Input channel in_valid / in_stall / in_data carries both positions, masses
// and radii; result channel out_valid / out_stall / out_data carries the
// acceleration and potential of both particles and the collision flag.
// A request is taken at an edge with valid high and stall low.
// Configuration: cfg_valid / cfg_ready with cfg_index (0 softening squared,
// 1 gravitational constant, 2 mass floor) and cfg_data; cfg_ready is always
// high and other indexes are dropped. Write only while the block is empty.
// Throughput: one pair per cycle unless the receiver stalls. Depth: 123
// register stages (seven front-end stages, a 16-stage square root, three
// chained 32-stage dividers, three product/shift stages and the result
// register).
// Reset (synchronous, rst_n low) clears every valid bit and loads the
// register defaults. When the receiver stalls a waiting result, the whole
// pipeline holds and in_stall rises in the same cycle; nothing is lost.
module gravity_pair_force_unit import gpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  gpf_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output gpf_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic en;

  logic [47:0] soft_r;
  logic [31:0] grav_r;
  logic [31:0] floor_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_r  <= SOFT_RST;
      grav_r  <= GRAV_RST;
      floor_r <= FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOFT:  soft_r  <= cfg_data;
        REG_GRAV:  grav_r  <= cfg_data[31:0];
        REG_FLOOR: floor_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Hold everything while a finished result waits
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Stage 1: separations, radius sum, light flags
  logic                     s1_vld_r;
  logic signed [32:0]       s1_d_r [3];
  logic [31:0]              s1_csum_r;
  logic [1:0][31:0]         s1_mass_r;
  logic [1:0]               s1_light_r;
  logic signed [31:0]       pa [3];
  logic signed [31:0]       pb [3];

  assign pa[0] = in_data.first_x;
  assign pa[1] = in_data.first_y;
  assign pa[2] = in_data.first_z;
  assign pb[0] = in_data.second_x;
  assign pb[1] = in_data.second_y;
  assign pb[2] = in_data.second_z;

  // Stage 2: magnitudes, pulls, squared contact distance
  logic             s2_vld_r;
  gpf_side_t        s2_side_r;
  logic [1:0][63:0] s2_n_r;
  logic [63:0]      s2_csq_r;
  gpf_side_t        s2_side_nxt;

  always_comb begin
    logic [32:0] a;
    s2_side_nxt = '0;
    s2_side_nxt.light = s1_light_r;
    for (int k = 0; k < 3; k++) begin
      a = s1_d_r[k][32] ? 33'(-s1_d_r[k]) : 33'(s1_d_r[k]);
      s2_side_nxt.ad[k]   = a[31:0];
      s2_side_nxt.dneg[k] = s1_d_r[k][32];
      s2_side_nxt.dpos[k] = !s1_d_r[k][32] && (s1_d_r[k] != 33'sd0);
    end
  end

  // Stage 3: squares
  logic             s3_vld_r;
  gpf_side_t        s3_side_r;
  logic [1:0][63:0] s3_n_r;
  logic [63:0]      s3_csq_r;
  logic [63:0]      s3_sq_r [3];

  // Stage 4: squared distance
  logic             s4_vld_r;
  gpf_side_t        s4_side_r;
  logic [1:0][63:0] s4_n_r;
  logic [63:0]      s4_csq_r;
  logic [65:0]      s4_r_r;

  // Stage 5: collision test, softened distance
  logic             s5_vld_r;
  gpf_side_t        s5_side_r;
  logic [1:0][63:0] s5_n_r;
  logic [65:0]      s5_d_r;
  gpf_side_t        s5_side_nxt;

  always_comb begin
    s5_side_nxt = s4_side_r;
    s5_side_nxt.collided = (s4_r_r <= {2'b00, s4_csq_r});
  end

  // Stage 6: leading-zero search
  logic             s6_vld_r;
  gpf_side_t        s6_side_r;
  logic [1:0][63:0] s6_n_r;
  logic [65:0]      s6_d_r;
  logic             s6_big_r;
  logic [4:0]       s6_k_r;
  logic [63:0]      s5_m0;
  logic [5:0]       s5_lz;

  assign s5_m0 = (s5_d_r[63:0] == 64'd0) ? 64'd1 : s5_d_r[63:0];
  assign s5_lz = lzc64(s5_m0);

  // Stage 7: normalised radicand and exponent
  logic             s7_vld_r;
  gpf_nside_t       s7_ns_r;
  logic [63:0]      s7_m_r;
  logic [63:0]      s6_m0;
  gpf_side_t        s7_side_nxt;

  assign s6_m0 = (s6_d_r[63:0] == 64'd0) ? 64'd1 : s6_d_r[63:0];

  always_comb begin
    s7_side_nxt   = s6_side_r;
    s7_side_nxt.e = s6_big_r ? 6'sd1 : 6'(-$signed({1'b0, s6_k_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
    end
  end

  // Front-end payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_d_r[k] <= 33'($signed({pa[k][31], pa[k]}) - $signed({pb[k][31], pb[k]}));
      end
      s1_csum_r     <= 32'(in_data.first_radius) + 32'(in_data.second_radius);
      s1_mass_r[0]  <= in_data.second_mass;
      s1_mass_r[1]  <= in_data.first_mass;
      s1_light_r[0] <= (in_data.second_mass <= floor_r);
      s1_light_r[1] <= (in_data.first_mass <= floor_r);

      s2_side_r <= s2_side_nxt;
      s2_n_r[0] <= 64'(grav_r) * 64'(s1_mass_r[0]);
      s2_n_r[1] <= 64'(grav_r) * 64'(s1_mass_r[1]);
      s2_csq_r  <= 64'(s1_csum_r) * 64'(s1_csum_r);

      s3_side_r <= s2_side_r;
      s3_n_r    <= s2_n_r;
      s3_csq_r  <= s2_csq_r;
      for (int k = 0; k < 3; k++) begin
        s3_sq_r[k] <= 64'(s2_side_r.ad[k]) * 64'(s2_side_r.ad[k]);
      end

      s4_side_r <= s3_side_r;
      s4_n_r    <= s3_n_r;
      s4_csq_r  <= s3_csq_r;
      s4_r_r    <= 66'(s3_sq_r[0]) + 66'(s3_sq_r[1]) + 66'(s3_sq_r[2]);

      s5_side_r <= s5_side_nxt;
      s5_n_r    <= s4_n_r;
      s5_d_r    <= s4_r_r + 66'(soft_r);

      s6_side_r <= s5_side_r;
      s6_n_r    <= s5_n_r;
      s6_d_r    <= s5_d_r;
      s6_big_r  <= (s5_d_r[65:64] != 2'b00);
      s6_k_r    <= s5_lz[5:1];

      s7_ns_r.side <= s7_side_nxt;
      s7_ns_r.n    <= s6_n_r;
      s7_m_r       <= s6_big_r ? s6_d_r[65:2] : (s6_m0 << {s6_k_r, 1'b0});
    end
  end

  // Square root of the normalised distance
  logic        sq_vld;
  logic [31:0] sq_s;
  gpf_nside_t  sq_ns;

  gpf_sqrt #(
    .SIDE_W ($bits(gpf_nside_t))
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (s7_vld_r),
    .m_i    (s7_m_r),
    .side_i (s7_ns_r),
    .vld_o  (sq_vld),
    .s_o    (sq_s),
    .side_o (sq_ns)
  );

  // Three chained divisions by the root
  logic             d1_vld, d2_vld, d3_vld;
  logic [1:0][63:0] d1_q, d2_q, d3_q;
  logic [31:0]      d1_s, d2_s;
  gpf_side_t        d1_side;
  gpf_qside_t       d2_in_side, d2_side, d3_side;

  gpf_div #(
    .SIDE_W ($bits(gpf_side_t))
  ) u_div1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (sq_vld),
    .x_i    (sq_ns.n),
    .s_i    (sq_s),
    .side_i (sq_ns.side),
    .vld_o  (d1_vld),
    .q_o    (d1_q),
    .s_o    (d1_s),
    .side_o (d1_side)
  );

  assign d2_in_side.side = d1_side;
  assign d2_in_side.q1   = d1_q;

  gpf_div #(
    .SIDE_W ($bits(gpf_qside_t))
  ) u_div2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (d1_vld),
    .x_i    (d1_q),
    .s_i    (d1_s),
    .side_i (d2_in_side),
    .vld_o  (d2_vld),
    .q_o    (d2_q),
    .s_o    (d2_s),
    .side_o (d2_side)
  );

  gpf_div #(
    .SIDE_W ($bits(gpf_qside_t))
  ) u_div3 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (d2_vld),
    .x_i    (d2_q),
    .s_i    (d2_s),
    .side_i (d2_side),
    .vld_o  (d3_vld),
    .q_o    (d3_q),
    .s_o    (),
    .side_o (d3_side)
  );

  // M1: partial products of q3 and each axis separation
  logic             m1_vld_r;
  gpf_qside_t       m1_qs_r;
  logic [63:0]      m1_pl_r [2][3];
  logic [63:0]      m1_ph_r [2][3];
  logic [6:0]       m1_amt_r;
  logic [5:0]       m1_pn_r;
  logic [7:0]       amt8, pn8;
  logic signed [7:0] e8;

  assign e8   = 8'(d3_side.side.e);
  assign amt8 = 8'(8'sd93 + e8 + e8 + e8);
  assign pn8  = 8'(8'sd39 + e8);

  // M2: full products
  logic             m2_vld_r;
  gpf_qside_t       m2_qs_r;
  logic [95:0]      m2_p_r [2][3];
  logic [6:0]       m2_amt_r;
  logic [5:0]       m2_pn_r;

  // M3: scaled and capped magnitudes
  logic             m3_vld_r;
  gpf_side_t        m3_side_r;
  logic [47:0]      m3_mag_r [2][3];
  logic [47:0]      m3_pot_r [2];
  logic [47:0]      mag_nxt  [2][3];
  logic [47:0]      pot_nxt  [2];

  always_comb begin
    logic [111:0] t;
    logic [63:0]  pt;
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 3; k++) begin
        t = {m2_p_r[j][k], 16'd0} >> m2_amt_r;
        if ((t[111:48] != '0) || (t[47] && (t[46:0] != '0))) mag_nxt[j][k] = MAG_CAP;
        else mag_nxt[j][k] = t[47:0];
      end
      pt = m2_qs_r.q1[j] >> m2_pn_r;
      if ((pt[63:48] != '0) || (pt[47] && (pt[46:0] != '0))) pot_nxt[j] = MAG_CAP;
      else pot_nxt[j] = pt[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= d3_vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_qs_r  <= d3_side;
      m1_amt_r <= amt8[6:0];
      m1_pn_r  <= pn8[5:0];
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 3; k++) begin
          m1_pl_r[j][k] <= 64'(d3_q[j][31:0])  * 64'(d3_side.side.ad[k]);
          m1_ph_r[j][k] <= 64'(d3_q[j][63:32]) * 64'(d3_side.side.ad[k]);
        end
      end

      m2_qs_r  <= m1_qs_r;
      m2_amt_r <= m1_amt_r;
      m2_pn_r  <= m1_pn_r;
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 3; k++) begin
          m2_p_r[j][k] <= {m1_ph_r[j][k], 32'd0} + 96'(m1_pl_r[j][k]);
        end
      end

      m3_side_r <= m2_qs_r.side;
      m3_mag_r  <= mag_nxt;
      m3_pot_r  <= pot_nxt;
    end
  end

  // Output register: apply signs, light partners and collision
  gpf_out_t    out_data_r;
  gpf_out_t    out_nxt;
  logic [47:0] acc_v [2][3];
  logic [47:0] pot_v [2];

  always_comb begin
    logic neg;
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 3; k++) begin
        neg = (j == 0) ? m3_side_r.dpos[k] : m3_side_r.dneg[k];
        if (neg) acc_v[j][k] = 48'(-m3_mag_r[j][k]);
        else if (m3_mag_r[j][k] == MAG_CAP) acc_v[j][k] = POS_MAX;
        else acc_v[j][k] = m3_mag_r[j][k];
        if (m3_side_r.collided || m3_side_r.light[j]) acc_v[j][k] = '0;
      end
      pot_v[j] = 48'(-m3_pot_r[j]);
      if (m3_side_r.collided || m3_side_r.light[j]) pot_v[j] = '0;
    end
    out_nxt.first_acc_x  = acc_v[0][0];
    out_nxt.first_acc_y  = acc_v[0][1];
    out_nxt.first_acc_z  = acc_v[0][2];
    out_nxt.first_pot    = pot_v[0];
    out_nxt.second_acc_x = acc_v[1][0];
    out_nxt.second_acc_y = acc_v[1][1];
    out_nxt.second_acc_z = acc_v[1][2];
    out_nxt.second_pot   = pot_v[1];
    out_nxt.collided     = m3_side_r.collided;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/gpf_checker.sv =====
module gpf_checker import gpf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input gpf_out_t    out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Input only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A collided pair carries no contribution
  a_collide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.collided |->
      out_data.first_acc_x == '0 && out_data.first_acc_y == '0 &&
      out_data.first_acc_z == '0 && out_data.first_pot == '0 &&
      out_data.second_acc_x == '0 && out_data.second_acc_y == '0 &&
      out_data.second_acc_z == '0 && out_data.second_pot == '0)
    else $error("collided pair with non-zero contribution");

  // Potentials never go positive
  a_pot_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.first_pot[47] || out_data.first_pot == '0) &&
                  (out_data.second_pot[47] || out_data.second_pot == '0))
    else $error("positive potential");

endmodule

bind gravity_pair_force_unit gpf_checker u_gpf_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench import gpf_pkg::*; ();

  localparam int PIPE_DEPTH  = 123;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  gpf_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  gpf_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  // Predictor copy of the configuration registers
  logic [47:0] soft_sq = SOFT_RST;
  logic [31:0] grav_k  = GRAV_RST;
  logic [31:0] floor_m = FLOOR_RST;

  gpf_out_t    pending_forces[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          stall_mode = 0;

  gravity_pair_force_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Softened pair force in exact wide arithmetic, saturated at the end
  function automatic gpf_out_t predict_force(gpf_in_t p);
    logic signed [32:0] d[3];
    logic [63:0]  ad[3];
    logic [63:0]  pull[2];
    logic [63:0]  csq, m, mm, s, rbit, n, q1, q2, q3;
    logic [127:0] r2, dsum;
    logic [191:0] w;
    logic [47:0]  mag;
    logic [47:0]  f[8];
    logic         neg;
    int           e, sh;
    gpf_out_t     o;
    d[0] = p.first_x - p.second_x;
    d[1] = p.first_y - p.second_y;
    d[2] = p.first_z - p.second_z;
    for (int k = 0; k < 3; k++) ad[k] = 64'(d[k] < 0 ? -d[k] : d[k]);
    for (int j = 0; j < 8; j++) f[j] = '0;
    o = '0;
    csq = 64'(p.first_radius) + 64'(p.second_radius);
    csq = csq * csq;
    r2 = 128'(ad[0] * ad[0]) + 128'(ad[1] * ad[1]) + 128'(ad[2] * ad[2]);
    if (r2 <= 128'(csq)) begin
      o.collided = 1'b1;
      return o;
    end
    // Normalise the softened distance to [2^62, 2^64) in powers of four
    dsum = r2 + 128'(soft_sq);
    e = 0;
    if (dsum[127:64] != 0) begin
      m = 64'(dsum >> 2);
      e = 1;
    end else begin
      m = (dsum[63:0] == 0) ? 64'd1 : dsum[63:0];
      while (m < (64'd1 << 62)) begin
        m = m << 2;
        e--;
      end
    end
    // Integer square root, digit by digit
    s = 0;
    mm = m;
    rbit = 64'd1 << 62;
    while (rbit > mm) rbit = rbit >> 2;
    while (rbit != 0) begin
      if (mm >= s + rbit) begin
        mm = mm - (s + rbit);
        s = (s >> 1) + rbit;
      end else begin
        s = s >> 1;
      end
      rbit = rbit >> 2;
    end
    pull[0] = 64'(p.second_mass);
    pull[1] = 64'(p.first_mass);
    for (int j = 0; j < 2; j++) begin
      if (pull[j] <= 64'(floor_m)) continue;
      n  = 64'(grav_k) * pull[j];
      q1 = 64'((128'(n) << 31) / 128'(s));
      q2 = 64'((128'(q1) << 31) / 128'(s));
      q3 = 64'((128'(q2) << 31) / 128'(s));
      sh = -77 - 3 * e;
      for (int k = 0; k < 3; k++) begin
        w = 192'(128'(q3) * 128'(ad[k]));
        if (sh >= 0) w = w << sh;
        else w = w >> (-sh);
        mag = (w > 192'(MAG_CAP)) ? MAG_CAP : w[47:0];
        neg = (j == 0) ? (d[k] > 0) : (d[k] < 0);
        if (mag == 0) f[j*4+k] = '0;
        else if (neg) f[j*4+k] = -mag;
        else f[j*4+k] = (mag > POS_MAX) ? POS_MAX : mag;
      end
      w = 192'(q1) >> (39 + e);
      mag = (w > 192'(MAG_CAP)) ? MAG_CAP : w[47:0];
      f[j*4+3] = -mag;
    end
    o.first_acc_x  = f[0];
    o.first_acc_y  = f[1];
    o.first_acc_z  = f[2];
    o.first_pot    = f[3];
    o.second_acc_x = f[4];
    o.second_acc_y = f[5];
    o.second_acc_z = f[6];
    o.second_pot   = f[7];
    return o;
  endfunction

  task automatic report(string fld, logic [47:0] got, logic [47:0] want);
    if (got !== want) begin
      mismatches++;
      $display("mismatch %s: got %h want %h at cycle %0d", fld, got, want, cycles);
    end
  endtask

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stall the result channel in phases: none, light, heavy
  always @(posedge clk) begin
    if (cycles % 97 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Compare each accepted result with the oldest expected force
  always @(posedge clk) begin
    gpf_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_forces.size() == 0) begin
        report("unexpected result", 48'd1, 48'd0);
      end else begin
        want = pending_forces.pop_front();
        report("first_acc_x", out_data.first_acc_x, want.first_acc_x);
        report("first_acc_y", out_data.first_acc_y, want.first_acc_y);
        report("first_acc_z", out_data.first_acc_z, want.first_acc_z);
        report("first_pot", out_data.first_pot, want.first_pot);
        report("second_acc_x", out_data.second_acc_x, want.second_acc_x);
        report("second_acc_y", out_data.second_acc_y, want.second_acc_y);
        report("second_acc_z", out_data.second_acc_z, want.second_acc_z);
        report("second_pot", out_data.second_pot, want.second_pot);
        report("collided", 48'(out_data.collided), 48'(want.collided));
      end
    end
  end

  // Send one pair request; bursts of random length, mostly separated by idle gaps
  task automatic send_pair(gpf_in_t p);
    int       gap;
    gpf_out_t expected_force;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 50);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    expected_force = predict_force(p);
    pending_forces = {pending_forces, expected_force};
  endtask

  // Hold input idle until every expected result has come back
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SOFT:  soft_sq = val;
      REG_GRAV:  grav_k  = val[31:0];
      REG_FLOOR: floor_m = val[31:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [47:0] soft_val, logic [47:0] grav, logic [47:0] flr);
    drain();
    write_reg(REG_SOFT, soft_val);
    write_reg(REG_GRAV, grav);
    write_reg(REG_FLOOR, flr);
  endtask

  // Random pair: mostly near neighbours, some far apart, some overlapping
  function automatic gpf_in_t rand_pair();
    gpf_in_t p;
    int      shift;
    p.first_x = $urandom;
    p.first_y = $urandom;
    p.first_z = $urandom;
    shift = $urandom_range(0, 31);
    if ($urandom_range(0, 4) == 0) begin
      p.second_x = $urandom;
      p.second_y = $urandom;
      p.second_z = $urandom;
    end else begin
      p.second_x = p.first_x + ($signed($urandom) >>> shift);
      p.second_y = p.first_y + ($signed($urandom) >>> $urandom_range(shift, 31));
      p.second_z = p.first_z + ($signed($urandom) >>> $urandom_range(shift, 31));
      if ($urandom_range(0, 7) == 0) p.second_y = p.first_y;
    end
    p.first_mass  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom;
    p.second_mass = ($urandom_range(0, 7) == 0) ? floor_m : $urandom;
    if ($urandom_range(0, 7) == 0) begin
      p.first_radius  = 31'($urandom);
      p.second_radius = 31'($urandom);
    end else begin
      p.first_radius  = 31'($urandom_range(0, 4095));
      p.second_radius = 31'($urandom_range(0, 4095));
    end
    return p;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_pair(rand_pair());
  endtask

  task automatic test_directed;
    gpf_in_t p;
    // Full-range separation on every axis, heavy partners
    p = '0;
    p.first_x = 32'sh7FFF_FFFF; p.first_y = 32'sh7FFF_FFFF; p.first_z = 32'sh7FFF_FFFF;
    p.second_x = 32'sh8000_0000; p.second_y = 32'sh8000_0000; p.second_z = 32'sh8000_0000;
    p.first_mass = '1; p.second_mass = '1;
    send_pair(p);
    p.first_x = 32'sh8000_0000; p.second_x = 32'sh7FFF_FFFF;
    send_pair(p);
    // Coincident particles with zero radii collide
    p = '0;
    send_pair(p);
    // Touching exactly at summed radii, then just outside
    p.first_mass = 32'h1000_0000; p.second_mass = 32'h2000_0000;
    p.first_x = 32'sd300; p.first_radius = 31'd100; p.second_radius = 31'd200;
    send_pair(p);
    p.first_x = 32'sd301;
    send_pair(p);
    // Largest radii against the full-range separation, which lies just beyond their sum
    p.first_radius = '1; p.second_radius = '1;
    p.first_x = 32'sh7FFF_FFFF; p.second_x = 32'sh8000_0000;
    send_pair(p);
    // Coincident axes, tiny separation, heavy masses: saturation
    p = '0;
    p.second_z = 32'sd1; p.first_mass = '1; p.second_mass = '1;
    send_pair(p);
    p.second_z = -32'sd1;
    send_pair(p);
    // Light partners at and below the floor
    p.second_x = 32'sd1 << 24; p.second_z = '0;
    p.first_mass = floor_m; p.second_mass = 32'h8000_0000;
    send_pair(p);
    p.first_mass = 32'h8000_0000; p.second_mass = '0;
    send_pair(p);
    p.first_mass = floor_m + 1; p.second_mass = floor_m + 1;
    send_pair(p);
    for (int i = 0; i < 10; i++) send_pair(rand_pair());
  endtask

  task automatic test_reset_config;
    run_random(350);
  endtask

  task automatic test_extreme_config;
    set_regs(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd0);
    test_directed();
    run_random(280);
  endtask

  task automatic test_heavy_floor;
    set_regs(48'({$urandom, $urandom}), 48'($urandom), 48'hFFFF_FFFF);
    run_random(150);
    // Writes to an unknown index must be dropped
    drain();
    write_reg(2'd3, 48'hFFFF_FFFF_FFFF);
    run_random(50);
  endtask

  task automatic test_zero_gravity;
    set_regs(48'd0, 48'd0, 48'd0);
    run_random(150);
  endtask

  task automatic test_random_config;
    for (int ph = 0; ph < 4; ph++) begin
      set_regs(48'($urandom) >> $urandom_range(0, 31) | (48'($urandom) << 32),
               48'($urandom) >> $urandom_range(0, 31), 48'($urandom_range(0, 65535)));
      run_random(100);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_reset_config();
    test_extreme_config();
    test_heavy_floor();
    test_zero_gravity();
    test_random_config();
    drain();
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gpf_pkg.sv
rtl/gpf_sqrt.sv
rtl/gpf_div.sv
rtl/gravity_pair_force_unit.sv
rtl/gpf_checker.sv
verif/testbench.sv
